>>> rtl/spq_pkg.sv
// Shared types, constants and pointer helpers for the sorted priority queue.
// No dependencies; imported by the queue top level.
package spq_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int COUNT_W     = 32;
    localparam int NODE_W      = 9;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = COUNT_W + NODE_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [NODE_W-1:0]  node;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_PLACE = 5'b00100,
        ST_POPRD = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    // Circular pointer step with wrap at any depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

>>> rtl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue (minimum first) held in one circular entry RAM.
// Depends on spq_pkg and spq_ram.
//
// Flow: one request at a time, taken only in the idle state. A pop reads the
// new head from the RAM before it responds; a pop that empties the queue, an
// error request or an insert into an empty queue goes straight to the response.
// An insert into a nonempty queue first scans backward from the tail, shifting
// each stored entry with a strictly greater count up one slot, and then writes
// the new entry. The scan moves one entry per cycle through the RAM write port.
// A result is shown on the m_ side in the cycle after the response state and then
// waits in its register without stopping the next request from being taken.
// Reset (aresetn low at a clock edge) clears occupancy, pointers and the
// handshake; RAM contents are left as they are, no clearing pass.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [COUNT_W-1:0] s_entry_count,
    input  logic [NODE_W-1:0]  s_entry_node,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_head_count,
    output logic [NODE_W-1:0]  m_head_node,
    output logic [NODE_W-1:0]  m_popped_node,
    output logic               m_queue_empty,
    output logic               m_overflow,
    output logic               m_underflow
);

    // Control state
    state_t             state_reg, state_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [PTR_W-1:0]   head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [PTR_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [OCC_W-1:0]   rem_reg, rem_next;
    logic               m_valid_reg, m_valid_next;

    // Payload: current request, cached head entry, result flags
    logic [COUNT_W-1:0] key_reg, key_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [COUNT_W-1:0] head_key_reg, head_key_next;
    logic [NODE_W-1:0]  head_node_reg, head_node_next;
    logic [NODE_W-1:0]  popped_reg, popped_next;
    logic               ovf_reg, ovf_next;
    logic               unf_reg, unf_next;
    logic [COUNT_W-1:0] m_head_count_reg, m_head_count_next;
    logic [NODE_W-1:0]  m_head_node_reg, m_head_node_next;
    logic [NODE_W-1:0]  m_popped_reg, m_popped_next;
    logic               m_empty_reg, m_empty_next;
    logic               m_ovf_reg, m_ovf_next;
    logic               m_unf_reg, m_unf_next;

    // RAM port signals
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    entry_t             ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    entry_t             new_entry;

    assign new_entry = '{count: key_reg, node: node_reg};
    assign ram_rdata = entry_t'(ram_rdata_raw);

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    always_comb begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        head_ptr_next     = head_ptr_reg;
        tail_ptr_next     = tail_ptr_reg;
        scan_ptr_next     = scan_ptr_reg;
        rem_next          = rem_reg;
        key_next          = key_reg;
        node_next         = node_reg;
        head_key_next     = head_key_reg;
        head_node_next    = head_node_reg;
        popped_next       = popped_reg;
        ovf_next          = ovf_reg;
        unf_next          = unf_reg;
        m_head_count_next = m_head_count_reg;
        m_head_node_next  = m_head_node_reg;
        m_popped_next     = m_popped_reg;
        m_empty_next      = m_empty_reg;
        m_ovf_next        = m_ovf_reg;
        m_unf_next        = m_unf_reg;
        // drop the shown result once it is taken
        m_valid_next      = m_valid_reg & ~m_ready;

        ram_we    = 1'b0;
        ram_waddr = tail_ptr_reg;
        ram_wdata = new_entry;
        ram_re    = 1'b0;
        ram_raddr = head_ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next    = s_entry_count;
                    node_next   = s_entry_node;
                    popped_next = '0;
                    ovf_next    = 1'b0;
                    unf_next    = 1'b0;
                    if (s_mode == MODE_INSERT) begin
                        if (occ_reg == OCC_W'(QUEUE_DEPTH)) begin
                            // full: drop the entry
                            ovf_next   = 1'b1;
                            state_next = ST_RESP;
                        end else if (occ_reg == '0) begin
                            // empty: write straight at the tail
                            ram_we         = 1'b1;
                            ram_waddr      = tail_ptr_reg;
                            ram_wdata      = '{count: s_entry_count, node: s_entry_node};
                            head_key_next  = s_entry_count;
                            head_node_next = s_entry_node;
                            tail_ptr_next  = ptr_inc(tail_ptr_reg);
                            occ_next       = occ_reg + 1'b1;
                            state_next     = ST_RESP;
                        end else begin
                            // start the scan from the last entry backward
                            ram_re        = 1'b1;
                            ram_raddr     = ptr_dec(tail_ptr_reg);
                            scan_ptr_next = ptr_dec(tail_ptr_reg);
                            rem_next      = occ_reg;
                            state_next    = ST_SCAN;
                        end
                    end else begin
                        if (occ_reg == '0) begin
                            unf_next   = 1'b1;
                            state_next = ST_RESP;
                        end else begin
                            popped_next   = head_node_reg;
                            head_ptr_next = ptr_inc(head_ptr_reg);
                            occ_next      = occ_reg - 1'b1;
                            if (occ_reg == OCC_W'(1)) begin
                                state_next = ST_RESP;
                            end else begin
                                // fetch the new head
                                ram_re     = 1'b1;
                                ram_raddr  = ptr_inc(head_ptr_reg);
                                state_next = ST_POPRD;
                            end
                        end
                    end
                end
            end

            ST_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_inc(scan_ptr_reg);
                if (ram_rdata.count > key_reg) begin
                    // shift the greater entry up one slot
                    ram_wdata = ram_rdata;
                    if (rem_reg == OCC_W'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_re        = 1'b1;
                        ram_raddr     = ptr_dec(scan_ptr_reg);
                        scan_ptr_next = ptr_dec(scan_ptr_reg);
                        rem_next      = rem_reg - 1'b1;
                    end
                end else begin
                    // stable insert: land after the last count not above the key
                    ram_wdata     = new_entry;
                    tail_ptr_next = ptr_inc(tail_ptr_reg);
                    occ_next      = occ_reg + 1'b1;
                    state_next    = ST_RESP;
                end
            end

            ST_PLACE: begin
                // every stored entry moved up: the new entry takes the head slot
                ram_we         = 1'b1;
                ram_waddr      = scan_ptr_reg;
                ram_wdata      = new_entry;
                head_key_next  = key_reg;
                head_node_next = node_reg;
                tail_ptr_next  = ptr_inc(tail_ptr_reg);
                occ_next       = occ_reg + 1'b1;
                state_next     = ST_RESP;
            end

            ST_POPRD: begin
                head_key_next  = ram_rdata.count;
                head_node_next = ram_rdata.node;
                state_next     = ST_RESP;
            end

            ST_RESP: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (occ_reg == '0) begin
                        m_head_count_next = '0;
                        m_head_node_next  = '0;
                        m_empty_next      = 1'b1;
                    end else begin
                        m_head_count_next = head_key_reg;
                        m_head_node_next  = head_node_reg;
                        m_empty_next      = 1'b0;
                    end
                    m_popped_next = popped_reg;
                    m_ovf_next    = ovf_reg;
                    m_unf_next    = unf_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            scan_ptr_reg <= '0;
            rem_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            scan_ptr_reg <= scan_ptr_next;
            rem_reg      <= rem_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg          <= key_next;
        node_reg         <= node_next;
        head_key_reg     <= head_key_next;
        head_node_reg    <= head_node_next;
        popped_reg       <= popped_next;
        ovf_reg          <= ovf_next;
        unf_reg          <= unf_next;
        m_head_count_reg <= m_head_count_next;
        m_head_node_reg  <= m_head_node_next;
        m_popped_reg     <= m_popped_next;
        m_empty_reg      <= m_empty_next;
        m_ovf_reg        <= m_ovf_next;
        m_unf_reg        <= m_unf_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_head_count  = m_head_count_reg;
    assign m_head_node   = m_head_node_reg;
    assign m_popped_node = m_popped_reg;
    assign m_queue_empty = m_empty_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_underflow   = m_unf_reg;

    // Occupancy never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // Occupancy moves by at most one entry per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + 1'b1) ||
            (occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy jumped");

    // The scan never reads the slot it writes in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write collide on one entry");

    // A result never carries both error flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_ovf_reg && m_unf_reg))
        else $error("overflow and underflow together");

endmodule
